>>> rtl/grid_component_labeler_macros.svh
// Assertion macros shared by the labeler RTL.
`ifndef GRID_COMPONENT_LABELER_MACROS_SVH
`define GRID_COMPONENT_LABELER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define GCL_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed");
`define GCL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define GCL_ASSERT_ALWAYS(label, clk, rst, cond)
`define GCL_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

>>> rtl/gcl_pkg.sv
// Types, constants and neighbour table shared by the labeler modules.
`timescale 1ns / 1ps
package gcl_pkg;

   localparam int ID_W      = 6;
   localparam int COORD_W   = 6;
   localparam int NBR_COUNT = 24;
   localparam int D_W       = 5;
   localparam int GRP_W     = 7;
   localparam int STACK_W   = ID_W + D_W;
   localparam int COORDS_W  = 2 * COORD_W;
   localparam int MAP_W     = ID_W + 1;

   typedef struct packed {
      logic [COORD_W-1:0] tile_x;
      logic [COORD_W-1:0] tile_y;
      logic               final_tile;
   } req_type;

   typedef struct packed {
      logic [ID_W-1:0] tile_index;
      logic [ID_W-1:0] group_number;
      logic            group_end;
      logic            run_end;
   } rsp_type;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_SCAN, S_SCAN_C, S_SCAN_M,
      S_PROBE, S_PROBE_M, S_POP_S, S_LOAD_C, S_DONE
   } state_type;

   typedef struct packed {
      logic clr_step;
      logic load;
      logic scan_open;
      logic scan_hit;
      logic scan_next;
      logic probe;
      logic probe_hit;
      logic pop;
      logic pop_latch;
      logic latch_coords;
      logic group_close;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic clr_last;
      logic tiles_done;
      logic cell_live;
      logic nbr_done;
      logic depth_one;
      logic nbr_outside;
   } status_type;

   // Column offset of neighbour d, in walk order.
   function automatic logic signed [2:0] nbr_dx(input logic [D_W-1:0] d);
      logic signed [2:0] r;
      case (d)
         5'd0:  r = 3'sd0;   5'd1:  r = 3'sd1;   5'd2:  r = 3'sd0;   5'd3:  r = -3'sd1;
         5'd4:  r = 3'sd1;   5'd5:  r = -3'sd1;  5'd6:  r = 3'sd1;   5'd7:  r = -3'sd1;
         5'd8:  r = 3'sd0;   5'd9:  r = -3'sd2;  5'd10: r = 3'sd0;   5'd11: r = 3'sd2;
         5'd12: r = -3'sd2;  5'd13: r = 3'sd2;   5'd14: r = 3'sd2;   5'd15: r = -3'sd2;
         5'd16: r = 3'sd1;   5'd17: r = 3'sd1;   5'd18: r = -3'sd1;  5'd19: r = -3'sd1;
         5'd20: r = 3'sd2;   5'd21: r = 3'sd2;   5'd22: r = -3'sd2;  5'd23: r = -3'sd2;
         default: r = 3'sd0;
      endcase
      return r;
   endfunction

   // Row offset of neighbour d, in walk order.
   function automatic logic signed [2:0] nbr_dy(input logic [D_W-1:0] d);
      logic signed [2:0] r;
      case (d)
         5'd0:  r = 3'sd1;   5'd1:  r = 3'sd0;   5'd2:  r = -3'sd1;  5'd3:  r = 3'sd0;
         5'd4:  r = 3'sd1;   5'd5:  r = 3'sd1;   5'd6:  r = -3'sd1;  5'd7:  r = -3'sd1;
         5'd8:  r = -3'sd2;  5'd9:  r = 3'sd0;   5'd10: r = 3'sd2;   5'd11: r = 3'sd0;
         5'd12: r = 3'sd2;   5'd13: r = 3'sd2;   5'd14: r = -3'sd2;  5'd15: r = -3'sd2;
         5'd16: r = 3'sd2;   5'd17: r = -3'sd2;  5'd18: r = 3'sd2;   5'd19: r = -3'sd2;
         5'd20: r = 3'sd1;   5'd21: r = -3'sd1;  5'd22: r = 3'sd1;   5'd23: r = -3'sd1;
         default: r = 3'sd0;
      endcase
      return r;
   endfunction

endpackage

>>> rtl/gcl_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module gcl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

>>> rtl/gcl_ctrl.sv
// Sequencer for the map clear, loading, scanning and depth-first walking of tiles.
`timescale 1ns / 1ps
`include "grid_component_labeler_macros.svh"
module gcl_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                final_tile,
   input  gcl_pkg::status_type status,
   output gcl_pkg::cmd_type    cmd,
   output logic                busy
);
   import gcl_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR:   if (status.clr_last) state_in = S_IDLE;
         S_IDLE:    if (start && final_tile) state_in = S_SCAN;
         S_SCAN:    state_in = status.tiles_done ? S_DONE : S_SCAN_C;
         S_SCAN_C:  state_in = S_SCAN_M;
         S_SCAN_M:  state_in = status.cell_live ? S_PROBE : S_SCAN;
         S_PROBE: begin
            if (status.nbr_done) begin
               state_in = status.depth_one ? S_SCAN : S_POP_S;
            end else if (!status.nbr_outside) begin
               state_in = S_PROBE_M;
            end
         end
         S_PROBE_M: state_in = status.cell_live ? S_LOAD_C : S_PROBE;
         S_POP_S:   state_in = S_LOAD_C;
         S_LOAD_C:  state_in = S_PROBE;
         S_DONE:    state_in = S_IDLE;
         default:   state_in = S_CLEAR;
      endcase
   end

   always_comb begin
      cmd = '0;
      case (state_ff)
         S_CLEAR:   cmd.clr_step = 1'b1;
         S_IDLE:    cmd.load = start;
         S_SCAN_C:  cmd.scan_open = 1'b1;
         S_SCAN_M: begin
            cmd.scan_hit  = status.cell_live;
            cmd.scan_next = !status.cell_live;
         end
         S_PROBE: begin
            cmd.group_close = status.nbr_done && status.depth_one;
            cmd.pop         = status.nbr_done && !status.depth_one;
            cmd.probe       = !status.nbr_done;
         end
         S_PROBE_M: cmd.probe_hit = status.cell_live;
         S_POP_S:   cmd.pop_latch = 1'b1;
         S_LOAD_C:  cmd.latch_coords = 1'b1;
         S_DONE:    cmd.finish = 1'b1;
         default:   cmd = '0;
      endcase
   end

   assign busy = (state_ff != S_IDLE);

   `GCL_ASSERT_NEXT(a_final_goes_busy, clock, reset, start && !busy && final_tile, busy)
   `GCL_ASSERT_NEXT(a_load_stays_ready, clock, reset, start && !busy && !final_tile, !busy)
   `GCL_ASSERT_NEXT(a_done_to_idle, clock, reset, state_ff == S_DONE, !busy)
endmodule

>>> rtl/gcl_datapath.sv
// Tile store, occupancy map, walk stack and result staging.
`timescale 1ns / 1ps
`include "grid_component_labeler_macros.svh"
module gcl_datapath #(
   parameter int GRID_SIDE = 64,
   parameter int MAX_TILES = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  gcl_pkg::req_type    req_item,
   input  gcl_pkg::cmd_type    cmd,
   output gcl_pkg::status_type status,
   output logic                rsp_valid,
   output gcl_pkg::rsp_type    rsp_item
);
   import gcl_pkg::*;

   localparam int MAP_DEPTH = GRID_SIDE * GRID_SIDE;
   localparam int CW        = $clog2(MAP_DEPTH);
   localparam int TAW       = $clog2(MAX_TILES);
   localparam int CNW       = $clog2(MAX_TILES + 1);

   logic [CW-1:0]      clr_addr_ff, clr_addr_in;
   logic [CNW-1:0]     count_ff, count_in;
   logic [CNW-1:0]     t_ff, t_in;
   logic [GRP_W-1:0]   group_ff, group_in;
   logic [CNW-1:0]     depth_ff, depth_in;
   logic [ID_W-1:0]    top_id_ff, top_id_in;
   logic [D_W-1:0]     top_d_ff, top_d_in;
   logic [COORD_W-1:0] top_x_ff, top_x_in, top_y_ff, top_y_in;
   logic [CW-1:0]      cell_ff, cell_in;
   logic               pend_v_ff, pend_v_in, pend_gend_ff, pend_gend_in;
   logic [ID_W-1:0]    pend_id_ff, pend_id_in, pend_grp_ff, pend_grp_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic               map_we;
   logic [CW-1:0]      map_waddr, map_raddr;
   logic [MAP_W-1:0]   map_wdata, map_rdata;
   logic               crd_we;
   logic [TAW-1:0]     crd_raddr;
   logic [COORDS_W-1:0] crd_rdata;
   logic               stk_we;
   logic [TAW-1:0]     stk_waddr, stk_raddr;
   logic [STACK_W-1:0] stk_rdata;

   logic               load_ok;
   logic [CW-1:0]      load_cell, scan_cell, nbr_cell;
   logic signed [7:0]  nx, ny;
   logic [CNW-1:0]     depth_m1, depth_m2;
   logic               emit_v;
   logic [ID_W-1:0]    emit_id;

   assign load_ok = (32'(req_item.tile_x) < GRID_SIDE) && (32'(req_item.tile_y) < GRID_SIDE)
                 && (32'(count_ff) < MAX_TILES);
   assign load_cell = CW'(req_item.tile_y) * CW'(GRID_SIDE) + CW'(req_item.tile_x);
   assign scan_cell = CW'(crd_rdata[COORDS_W-1:COORD_W]) * CW'(GRID_SIDE)
                    + CW'(crd_rdata[COORD_W-1:0]);
   assign nx = $signed({2'b00, top_x_ff}) + 8'(nbr_dx(top_d_ff));
   assign ny = $signed({2'b00, top_y_ff}) + 8'(nbr_dy(top_d_ff));
   assign nbr_cell = CW'(ny[COORD_W-1:0]) * CW'(GRID_SIDE) + CW'(nx[COORD_W-1:0]);
   assign depth_m1 = depth_ff - CNW'(1);
   assign depth_m2 = depth_ff - CNW'(2);

   assign status.clr_last    = (clr_addr_ff == CW'(MAP_DEPTH - 1));
   assign status.tiles_done  = (t_ff >= count_ff);
   assign status.cell_live   = map_rdata[MAP_W-1];
   assign status.nbr_done    = (top_d_ff >= D_W'(NBR_COUNT));
   assign status.depth_one   = (depth_ff == CNW'(1));
   assign status.nbr_outside = nx[7] || ny[7] || (32'(nx) >= GRID_SIDE)
                            || (32'(ny) >= GRID_SIDE);

   // Memory port steering
   always_comb begin
      map_we    = 1'b0;
      map_waddr = cell_ff;
      map_wdata = '0;
      if (cmd.clr_step) begin
         map_we    = 1'b1;
         map_waddr = clr_addr_ff;
      end else if (cmd.load) begin
         map_we    = load_ok;
         map_waddr = load_cell;
         map_wdata = {1'b1, ID_W'(count_ff)};
      end else if (cmd.scan_hit || cmd.probe_hit) begin
         map_we    = 1'b1;
      end
      map_raddr = cmd.scan_open ? scan_cell : nbr_cell;

      crd_we = cmd.load && load_ok;
      if (cmd.probe_hit) begin
         crd_raddr = map_rdata[TAW-1:0];
      end else if (cmd.pop_latch) begin
         crd_raddr = stk_rdata[D_W+TAW-1:D_W];
      end else begin
         crd_raddr = t_ff[TAW-1:0];
      end

      stk_we    = cmd.probe_hit;
      stk_waddr = depth_m1[TAW-1:0];
      stk_raddr = depth_m2[TAW-1:0];
   end

   assign emit_v  = cmd.scan_hit || cmd.probe_hit;
   assign emit_id = cmd.scan_hit ? ID_W'(t_ff) : map_rdata[ID_W-1:0];

   always_comb begin
      clr_addr_in  = clr_addr_ff;
      count_in     = count_ff;
      t_in         = t_ff;
      group_in     = group_ff;
      depth_in     = depth_ff;
      top_id_in    = top_id_ff;
      top_d_in     = top_d_ff;
      top_x_in     = top_x_ff;
      top_y_in     = top_y_ff;
      cell_in      = cell_ff;
      pend_v_in    = pend_v_ff;
      pend_id_in   = pend_id_ff;
      pend_grp_in  = pend_grp_ff;
      pend_gend_in = pend_gend_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;

      if (cmd.clr_step) clr_addr_in = clr_addr_ff + CW'(1);
      if (cmd.load) begin
         t_in = '0;
         if (load_ok) count_in = count_ff + CNW'(1);
      end
      if (cmd.scan_open || cmd.latch_coords) begin
         top_x_in = crd_rdata[COORD_W-1:0];
         top_y_in = crd_rdata[COORDS_W-1:COORD_W];
      end
      if (cmd.scan_open) begin
         cell_in   = scan_cell;
         top_id_in = ID_W'(t_ff);
         top_d_in  = '0;
      end
      if (cmd.scan_hit) depth_in = CNW'(1);
      if (cmd.scan_next || cmd.group_close) t_in = t_ff + CNW'(1);
      if (cmd.probe) begin
         top_d_in = top_d_ff + D_W'(1);
         cell_in  = nbr_cell;
      end
      if (cmd.probe_hit) begin
         depth_in  = depth_ff + CNW'(1);
         top_id_in = map_rdata[ID_W-1:0];
         top_d_in  = '0;
      end
      if (cmd.pop) depth_in = depth_m1;
      if (cmd.pop_latch) begin
         top_id_in = stk_rdata[STACK_W-1:D_W];
         top_d_in  = stk_rdata[D_W-1:0];
      end
      // One result is held back until the next one, or the end, shows its flags.
      if (emit_v) begin
         rsp_valid_in = pend_v_ff;
         rsp_in       = '{pend_id_ff, pend_grp_ff, pend_gend_ff, 1'b0};
         pend_v_in    = 1'b1;
         pend_id_in   = emit_id;
         pend_grp_in  = group_ff[ID_W-1:0];
         pend_gend_in = 1'b0;
      end
      if (cmd.group_close) begin
         pend_gend_in = 1'b1;
         group_in     = group_ff + GRP_W'(1);
      end
      if (cmd.finish) begin
         rsp_valid_in = pend_v_ff;
         rsp_in       = '{pend_id_ff, pend_grp_ff, pend_gend_ff, 1'b1};
         pend_v_in    = 1'b0;
         count_in     = '0;
         group_in     = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff  <= '0;
         count_ff     <= '0;
         t_ff         <= '0;
         group_ff     <= '0;
         depth_ff     <= '0;
         pend_v_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clr_addr_ff  <= clr_addr_in;
         count_ff     <= count_in;
         t_ff         <= t_in;
         group_ff     <= group_in;
         depth_ff     <= depth_in;
         pend_v_ff    <= pend_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      top_id_ff    <= top_id_in;
      top_d_ff     <= top_d_in;
      top_x_ff     <= top_x_in;
      top_y_ff     <= top_y_in;
      cell_ff      <= cell_in;
      pend_id_ff   <= pend_id_in;
      pend_grp_ff  <= pend_grp_in;
      pend_gend_ff <= pend_gend_in;
      rsp_ff       <= rsp_in;
   end

   gcl_ram #(.WIDTH(MAP_W), .DEPTH(MAP_DEPTH)) u_map (
      .clock(clock), .wr_en(map_we), .wr_addr(map_waddr), .wr_data(map_wdata),
      .rd_addr(map_raddr), .rd_data(map_rdata)
   );

   gcl_ram #(.WIDTH(COORDS_W), .DEPTH(MAX_TILES)) u_coords (
      .clock(clock), .wr_en(crd_we), .wr_addr(count_ff[TAW-1:0]),
      .wr_data({req_item.tile_y, req_item.tile_x}),
      .rd_addr(crd_raddr), .rd_data(crd_rdata)
   );

   gcl_ram #(.WIDTH(STACK_W), .DEPTH(MAX_TILES)) u_stack (
      .clock(clock), .wr_en(stk_we), .wr_addr(stk_waddr),
      .wr_data({top_id_ff, top_d_ff}),
      .rd_addr(stk_raddr), .rd_data(stk_rdata)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   `GCL_ASSERT_ALWAYS(a_depth_bound, clock, reset, 32'(depth_ff) <= MAX_TILES)
   `GCL_ASSERT_NEXT(a_no_back_to_back, clock, reset, rsp_valid_ff, !rsp_valid_ff)
   `GCL_ASSERT_ALWAYS(a_run_end_closes_group, clock, reset,
      !(rsp_valid_ff && rsp_ff.run_end) || rsp_ff.group_end)
endmodule

>>> rtl/grid_component_labeler.sv
// Top level of the grid tile component labeler.
`timescale 1ns / 1ps
// Tiles are loaded one item per cycle (start high while busy is low); each of
// the first MAX_TILES gets the next load-order id. The item with final_tile set
// is loaded too, then the block goes busy and labels every tile: tiles within a
// 5x5 neighbourhood of each other share a group. Groups open in id order and are
// walked depth-first; one result per tile comes out on rsp_item, flagged by
// rsp_valid for a single cycle, and cannot be held off. Each tile tried as a
// group start takes a coordinate read, a map read and a test; each of the 24
// neighbour probes goes through the occupancy map RAM's registered read (unless
// the neighbour lies off the grid), and a final step retires a tile's neighbour
// list. Each tile reached as a neighbour adds a coordinate fetch on arrival,
// then a stack read and a coordinate fetch when the walk backs out of it. A
// closing step releases the last result. After reset the occupancy map is swept
// clear, all GRID_SIDE*GRID_SIDE cells (4096 by default), with busy high; the
// walk itself leaves the map empty after a run.
module grid_component_labeler #(
   parameter int GRID_SIDE = 64,
   parameter int MAX_TILES = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  gcl_pkg::req_type req_item,
   output logic             rsp_valid,
   output gcl_pkg::rsp_type rsp_item
);
   import gcl_pkg::*;

   cmd_type    cmd;
   status_type status;

   gcl_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .final_tile(req_item.final_tile),
      .status(status), .cmd(cmd), .busy(busy)
   );

   gcl_datapath #(.GRID_SIDE(GRID_SIDE), .MAX_TILES(MAX_TILES)) u_dp (
      .clock(clock), .reset(reset), .req_item(req_item), .cmd(cmd),
      .status(status), .rsp_valid(rsp_valid), .rsp_item(rsp_item)
   );
endmodule

>>> bench/tb_grid_component_labeler.sv
// Self-checking bench for the grid tile component labeler.
`timescale 1ns / 1ps
module tb_grid_component_labeler;
   import gcl_pkg::*;

   // Clock, reset and block ports
   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_item;
   logic    rsp_valid;
   rsp_type rsp_item;

   grid_component_labeler u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   // Neighbour walk order: column and row offsets, radius 2, 24 entries
   localparam int WALK_DX [0:23] = '{0, 1, 0, -1, 1, -1, 1, -1, 0, -2, 0, 2,
                                     -2, 2, 2, -2, 1, 1, -1, -1, 2, 2, -2, -2};
   localparam int WALK_DY [0:23] = '{1, 0, -1, 0, 1, 1, -1, -1, -2, 0, 2, 0,
                                     2, 2, -2, -2, 2, -2, 2, -2, 1, -1, 1, -1};
   localparam int TILE_CAP = 64;
   localparam int SIDE     = 64;

   // Bench-side copy of the block's state
   logic [6:0]  grid_cells [0:SIDE*SIDE-1];
   logic [11:0] tile_pos   [0:TILE_CAP-1];
   logic [10:0] dfs_stack  [0:TILE_CAP-1];
   int          tiles_held;
   int          group_no;

   req_type pending_items [$];   // items still to drive
   rsp_type labels_due    [$];   // expected results, oldest first
   int      errors;
   logic    took;                // item accepted at the last rising edge
   int      gap_left;
   logic    calm;                // stretch with no idling
   int      calm_left;

   // Clock: 10 ns period
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic mismatch_note(input string what);
      $display("mismatch at %0t: %s", $realtime, what);
      errors++;
   endtask

   // Predict the labels one accepted item causes and queue them.
   task automatic label_item(input req_type it);
      rsp_type found [$];
      rsp_type r;
      int      sp, d, id, nx, ny, cell_idx, prior_count;
      logic [6:0] v;
      if (tiles_held < TILE_CAP) begin
         tile_pos[tiles_held] = {it.tile_y, it.tile_x};
         grid_cells[{it.tile_y, it.tile_x}] = {1'b1, 6'(tiles_held)};
         tiles_held++;
      end
      if (!it.final_tile) return;
      for (int t = 0; t < tiles_held; t++) begin
         cell_idx = tile_pos[t];
         if (!grid_cells[cell_idx][6]) continue;
         prior_count = found.size();
         grid_cells[cell_idx] = '0;
         if (found.size() < TILE_CAP) begin
            r = '{tile_index: 6'(t), group_number: 6'(group_no), group_end: 1'b0,
                  run_end: 1'b0};
            found = {found, r};
         end
         dfs_stack[0] = {6'(t), 5'd0};
         sp = 1;
         while (sp > 0) begin
            id = dfs_stack[sp-1][10:5];
            d  = dfs_stack[sp-1][4:0];
            if (d >= 24) begin
               sp--;
               continue;
            end
            dfs_stack[sp-1] = {6'(id), 5'(d + 1)};
            nx = int'(tile_pos[id][5:0]) + WALK_DX[d];
            ny = int'(tile_pos[id][11:6]) + WALK_DY[d];
            if (nx < 0 || nx >= SIDE || ny < 0 || ny >= SIDE) continue;
            v = grid_cells[ny*SIDE + nx];
            if (!v[6]) continue;
            grid_cells[ny*SIDE + nx] = '0;
            if (found.size() < TILE_CAP) begin
               r = '{tile_index: v[5:0], group_number: 6'(group_no), group_end: 1'b0,
                     run_end: 1'b0};
               found = {found, r};
            end
            if (sp < TILE_CAP) begin
               dfs_stack[sp] = {v[5:0], 5'd0};
               sp++;
            end
         end
         if (found.size() > prior_count) found[found.size()-1].group_end = 1'b1;
         group_no = (group_no + 1) & 127;
      end
      if (found.size() > 0) found[found.size()-1].run_end = 1'b1;
      foreach (found[i]) labels_due = {labels_due, found[i]};
      foreach (grid_cells[i]) grid_cells[i] = '0;
      tiles_held = 0;
      group_no   = 0;
   endtask

   task automatic add_tile(input int x, input int y, input logic fin);
      req_type it;
      it.tile_x     = 6'(x);
      it.tile_y     = 6'(y);
      it.final_tile = fin;
      pending_items = {pending_items, it};
   endtask

   // Driver: changes inputs on the falling edge, one assignment per signal
   always @(negedge clock) begin
      if (reset) begin
         start    <= 1'b0;
         gap_left <= 0;
      end else if (start && !took) begin
         // item still waiting for busy to drop: hold it
      end else if (gap_left > 0) begin
         start    <= 1'b0;
         gap_left <= gap_left - 1;
      end else if (pending_items.size() > 0) begin
         req_item <= pending_items.pop_front();
         start    <= 1'b1;
         if (calm_left == 0) begin
            calm      = ($urandom_range(0, 3) == 0);
            calm_left = $urandom_range(4, 20);
         end
         calm_left--;
         gap_left <= calm ? 0 : $urandom_range(0, 7);
      end else begin
         start <= 1'b0;
      end
   end

   // Monitor: acceptance and result checks on the rising edge
   always @(posedge clock) begin
      rsp_type due;
      if (reset) begin
         took <= 1'b0;
      end else begin
         took <= start && !busy;
         if (start && !busy) label_item(req_item);
         if (rsp_valid) begin
            if (labels_due.size() == 0) begin
               mismatch_note("result with nothing expected");
            end else begin
               due = labels_due.pop_front();
               if (rsp_item.tile_index !== due.tile_index)
                  mismatch_note($sformatf("tile_index %0d, want %0d",
                                          rsp_item.tile_index, due.tile_index));
               if (rsp_item.group_number !== due.group_number)
                  mismatch_note($sformatf("group_number %0d, want %0d",
                                          rsp_item.group_number, due.group_number));
               if (rsp_item.group_end !== due.group_end)
                  mismatch_note($sformatf("group_end %0b, want %0b",
                                          rsp_item.group_end, due.group_end));
               if (rsp_item.run_end !== due.run_end)
                  mismatch_note($sformatf("run_end %0b, want %0b",
                                          rsp_item.run_end, due.run_end));
            end
         end
      end
   end

   // Stimulus and end of run
   initial begin
      int n, bx, by, spread, sent;
      reset      = 1'b1;
      start      = 1'b0;
      req_item   = '0;
      took       = 1'b0;
      gap_left   = 0;
      calm       = 1'b0;
      calm_left  = 0;
      errors     = 0;
      tiles_held = 0;
      group_no   = 0;
      foreach (grid_cells[i]) grid_cells[i] = '0;

      // single tile at the origin
      add_tile(0, 0, 1'b1);
      // corners, diagonal radius-2 link, gap of 3, a duplicate position
      add_tile(63, 63, 1'b0);
      add_tile(61, 61, 1'b0);
      add_tile(0, 63, 1'b0);
      add_tile(63, 0, 1'b0);
      add_tile(62, 2, 1'b0);
      add_tile(30, 30, 1'b0);
      add_tile(33, 30, 1'b0);
      add_tile(30, 32, 1'b0);
      add_tile(31, 28, 1'b0);
      add_tile(30, 30, 1'b0);
      add_tile(5, 5, 1'b1);
      // knight-step chain, a stray tile, duplicate that orphans a tile
      add_tile(20, 20, 1'b0);
      add_tile(21, 22, 1'b0);
      add_tile(22, 24, 1'b0);
      add_tile(24, 25, 1'b0);
      add_tile(40, 40, 1'b0);
      add_tile(21, 22, 1'b0);
      add_tile(1, 62, 1'b1);
      // two tiles back to back
      add_tile(7, 9, 1'b0);
      add_tile(9, 7, 1'b1);

      // full tile store: dense cluster past the 64-tile limit
      bx = $urandom_range(0, 63);
      by = $urandom_range(0, 63);
      for (int i = 0; i < 70; i++)
         add_tile((bx + $urandom_range(0, 11)) & 63, (by + $urandom_range(0, 11)) & 63,
                  i == 69);
      // small sets, mostly clustered, some scattered over the whole grid
      sent = 0;
      while (sent < 30) begin
         n      = $urandom_range(1, 12);
         spread = ($urandom_range(0, 3) == 0) ? 63 : $urandom_range(2, 9);
         bx     = $urandom_range(0, 63);
         by     = $urandom_range(0, 63);
         for (int i = 0; i < n; i++)
            add_tile((bx + $urandom_range(0, spread)) & 63,
                     (by + $urandom_range(0, spread)) & 63, i == n - 1);
         sent += n;
      end

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      while (pending_items.size() > 0 || start) @(posedge clock);
      while (labels_due.size() > 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (labels_due.size() > 0)
         mismatch_note($sformatf("%0d results never came", labels_due.size()));
      if (errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #5ms;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
